>>> hdl/genotype_pair_contingency_macros.svh
// Assertion macros for the genotype pair contingency block.
// Define ASSERT_OFF to compile every check to nothing.
`ifndef GENOTYPE_PAIR_CONTINGENCY_MACROS_SVH
`define GENOTYPE_PAIR_CONTINGENCY_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check that is ignored while reset is asserted.
`define GPC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("genotype_pair_contingency: check failed");

// Clocked check that also holds while reset is asserted.
`define GPC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("genotype_pair_contingency: check failed during reset");

`else

`define GPC_ASSERT(label, prop)
`define GPC_ASSERT_ALWAYS(label, prop)

`endif

`endif

>>> hdl/gpc_pkg.sv
`default_nettype none

package gpc_pkg;

    // Field widths fixed by the interface.
    localparam int GROUP_W = 2;
    localparam int DATA_W  = 64;
    localparam int CNT_W   = 17;
    localparam int POP_W   = 7;

    // Number of sample groups and counters held for each group.
    localparam int NGROUPS = 4;
    localparam int NSLOTS  = 9;

    // Counter slots within a group: four joint counts, then five marginals.
    localparam int J00  = 0;
    localparam int J01  = 1;
    localparam int J10  = 2;
    localparam int J11  = 3;
    localparam int M1G0 = 4;
    localparam int M1G1 = 5;
    localparam int M2G0 = 6;
    localparam int M2G1 = 7;
    localparam int M2G2 = 8;

    // Group codes.
    localparam logic [GROUP_W-1:0] GRP_CTRL_FEMALE = 2'd0;
    localparam logic [GROUP_W-1:0] GRP_CTRL_MALE   = 2'd1;
    localparam logic [GROUP_W-1:0] GRP_CASE_FEMALE = 2'd2;
    localparam logic [GROUP_W-1:0] GRP_CASE_MALE   = 2'd3;

    // Parameter defaults.
    localparam int MAX_WORDS_PER_GROUP_DEF = 1024;
    localparam int WORD_BITS_DEF           = 64;

    // Largest value a counter can hold.
    localparam logic [CNT_W-1:0] CELL_MAX = '1;

    // Field masks for the parallel bit count.
    localparam logic [DATA_W-1:0] POP_M1 = 64'h5555_5555_5555_5555;
    localparam logic [DATA_W-1:0] POP_M2 = 64'h3333_3333_3333_3333;
    localparam logic [DATA_W-1:0] POP_M4 = 64'h0f0f_0f0f_0f0f_0f0f;
    localparam logic [DATA_W-1:0] POP_M7 = 64'h0000_0000_0000_007f;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [POP_W-1:0] pop_t;

    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic [DATA_W-1:0]  snp1_g0_word;
        logic [DATA_W-1:0]  snp1_g1_word;
        logic [DATA_W-1:0]  snp2_g0_word;
        logic [DATA_W-1:0]  snp2_g1_word;
        logic [DATA_W-1:0]  snp2_g2_word;
        logic               end_of_pair;
    } in_word_t;

    typedef struct packed {
        logic [GROUP_W-1:0] out_group;
        cnt_t               cell_00;
        cnt_t               cell_01;
        cnt_t               cell_02;
        cnt_t               cell_10;
        cnt_t               cell_11;
        cnt_t               cell_12;
        cnt_t               cell_20;
        cnt_t               cell_21;
        cnt_t               cell_22;
        logic               table_last;
    } out_word_t;

    // Number of set bits in a 64-bit word, summed in widening bit fields.
    function automatic pop_t popcount(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] x;
        x = v - ((v >> 1) & POP_M1);
        x = (x & POP_M2) + ((x >> 2) & POP_M2);
        x = (x + (x >> 4)) & POP_M4;
        x = x + (x >> 8);
        x = x + (x >> 16);
        x = x + (x >> 32);
        return pop_t'(x & POP_M7);
    endfunction

    // Counter add that clamps at the cap.
    function automatic cnt_t sat_add(input cnt_t c, input pop_t n, input cnt_t cap);
        logic [CNT_W:0] s;
        s = {1'b0, c} + (CNT_W + 1)'(n);
        return (s > {1'b0, cap}) ? cap : s[CNT_W-1:0];
    endfunction

    // Marginal minus two joint counts, clamped at zero.
    function automatic cnt_t sub_sat(input cnt_t m, input cnt_t a, input cnt_t b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return ({1'b0, m} < s) ? '0 : (m - s[CNT_W-1:0]);
    endfunction

endpackage

`default_nettype wire

>>> hdl/genotype_pair_contingency.sv
// Genotype pair contingency: accepts one word per clock while in_ready is high,
// each word carrying one 64-sample bitmap slice of two SNPs for one of four
// sample groups, and keeps nine saturating counters per group. A word flows
// through an input register, a popcount register and the counter update, and
// the tables of a closing word are then loaded into the output register.
// A word marked end_of_pair copies all counters into an output bank and clears
// them; the four tables (groups 0 to 3, the last one flagged) then leave one
// per cycle through the output register when the receiver is ready, and new
// words keep accumulating meanwhile. A following end_of_pair word waits in the
// popcount register until the cycle after the previous four tables have all
// entered the output register, so pairs shorter than five words are held back
// and longer pairs run at one word per cycle while the receiver keeps up.
`default_nettype none

`include "genotype_pair_contingency_macros.svh"

module genotype_pair_contingency #(
    parameter int MAX_WORDS_PER_GROUP = gpc_pkg::MAX_WORDS_PER_GROUP_DEF,
    parameter int WORD_BITS           = gpc_pkg::WORD_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire gpc_pkg::in_word_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output gpc_pkg::out_word_t     out_data
);

    localparam longint RAW_CAP = longint'(MAX_WORDS_PER_GROUP) * longint'(WORD_BITS);
    localparam gpc_pkg::cnt_t CNT_CAP =
        (RAW_CAP > longint'(gpc_pkg::CELL_MAX)) ? gpc_pkg::CELL_MAX
                                                : gpc_pkg::cnt_t'(RAW_CAP);
    localparam logic [gpc_pkg::DATA_W-1:0] WORD_MASK =
        (WORD_BITS >= gpc_pkg::DATA_W) ? '1
            : ((gpc_pkg::DATA_W)'(1) << WORD_BITS) - (gpc_pkg::DATA_W)'(1);

    // Input register.
    logic              in_valid_reg;
    gpc_pkg::in_word_t in_data_reg;
    logic              in_move;

    // Popcount register.
    logic                         pop_valid_reg;
    logic [gpc_pkg::GROUP_W-1:0]  pop_group_reg;
    logic                         pop_last_reg;
    gpc_pkg::pop_t                pop_reg [gpc_pkg::NSLOTS];
    gpc_pkg::pop_t                pop_next [gpc_pkg::NSLOTS];
    logic                         pop_ready;
    logic                         pop_take;

    // Counters and the bank the tables are read from.
    gpc_pkg::cnt_t cnt_reg  [gpc_pkg::NGROUPS][gpc_pkg::NSLOTS];
    gpc_pkg::cnt_t cnt_next [gpc_pkg::NGROUPS][gpc_pkg::NSLOTS];
    gpc_pkg::cnt_t bank_reg [gpc_pkg::NGROUPS][gpc_pkg::NSLOTS];
    gpc_pkg::cnt_t upd      [gpc_pkg::NSLOTS];

    // Table emitter and output register.
    logic                         emit_busy_reg;
    logic [gpc_pkg::GROUP_W-1:0]  emit_idx_reg;
    logic                         emit_load;
    logic                         out_valid_reg;
    gpc_pkg::out_word_t           out_data_reg;
    gpc_pkg::out_word_t           table_next;
    gpc_pkg::cnt_t                c02;
    gpc_pkg::cnt_t                c12;

    // Handshake chain: each stage frees up when its word moves on.
    assign pop_take  = pop_valid_reg && (!pop_last_reg || !emit_busy_reg);
    assign pop_ready = !pop_valid_reg || pop_take;
    assign in_move   = in_valid_reg && pop_ready;
    assign in_ready  = !in_valid_reg || pop_ready;

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // Popcounts of the four joint ANDs and five marginals, word width masked.
    always_comb
    begin
        logic [gpc_pkg::DATA_W-1:0] a0;
        logic [gpc_pkg::DATA_W-1:0] a1;
        logic [gpc_pkg::DATA_W-1:0] b0;
        logic [gpc_pkg::DATA_W-1:0] b1;
        logic [gpc_pkg::DATA_W-1:0] b2;
        a0 = in_data_reg.snp1_g0_word & WORD_MASK;
        a1 = in_data_reg.snp1_g1_word & WORD_MASK;
        b0 = in_data_reg.snp2_g0_word & WORD_MASK;
        b1 = in_data_reg.snp2_g1_word & WORD_MASK;
        b2 = in_data_reg.snp2_g2_word & WORD_MASK;
        pop_next[gpc_pkg::J00]  = gpc_pkg::popcount(a0 & b0);
        pop_next[gpc_pkg::J01]  = gpc_pkg::popcount(a0 & b1);
        pop_next[gpc_pkg::J10]  = gpc_pkg::popcount(a1 & b0);
        pop_next[gpc_pkg::J11]  = gpc_pkg::popcount(a1 & b1);
        pop_next[gpc_pkg::M1G0] = gpc_pkg::popcount(a0);
        pop_next[gpc_pkg::M1G1] = gpc_pkg::popcount(a1);
        pop_next[gpc_pkg::M2G0] = gpc_pkg::popcount(b0);
        pop_next[gpc_pkg::M2G1] = gpc_pkg::popcount(b1);
        pop_next[gpc_pkg::M2G2] = gpc_pkg::popcount(b2);
    end

    // Popcount register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_valid_reg <= 1'b0;
        end
        else if (pop_ready)
        begin
            pop_valid_reg <= in_move;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_move)
        begin
            pop_group_reg <= in_data_reg.group;
            pop_last_reg  <= in_data_reg.end_of_pair;
            pop_reg       <= pop_next;
        end
    end

    // Counter update: add into the word's group; on the last word move the
    // totals to the bank and start from zero.
    always_comb
    begin
        for (int s = 0; s < gpc_pkg::NSLOTS; s++)
        begin
            upd[s] = gpc_pkg::sat_add(cnt_reg[pop_group_reg][s], pop_reg[s], CNT_CAP);
        end
        cnt_next = cnt_reg;
        if (pop_take)
        begin
            if (pop_last_reg)
            begin
                for (int g = 0; g < gpc_pkg::NGROUPS; g++)
                begin
                    for (int s = 0; s < gpc_pkg::NSLOTS; s++)
                    begin
                        cnt_next[g][s] = '0;
                    end
                end
            end
            else
            begin
                cnt_next[pop_group_reg] = upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < gpc_pkg::NGROUPS; g++)
            begin
                for (int s = 0; s < gpc_pkg::NSLOTS; s++)
                begin
                    cnt_reg[g][s] <= '0;
                end
            end
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_take && pop_last_reg)
        begin
            for (int g = 0; g < gpc_pkg::NGROUPS; g++)
            begin
                if (pop_group_reg == gpc_pkg::GROUP_W'(g))
                begin
                    bank_reg[g] <= upd;
                end
                else
                begin
                    bank_reg[g] <= cnt_reg[g];
                end
            end
        end
    end

    // Table of the group being emitted, derived cells clamped at zero.
    always_comb
    begin
        c02 = gpc_pkg::sub_sat(bank_reg[emit_idx_reg][gpc_pkg::M1G0],
                               bank_reg[emit_idx_reg][gpc_pkg::J00],
                               bank_reg[emit_idx_reg][gpc_pkg::J01]);
        c12 = gpc_pkg::sub_sat(bank_reg[emit_idx_reg][gpc_pkg::M1G1],
                               bank_reg[emit_idx_reg][gpc_pkg::J10],
                               bank_reg[emit_idx_reg][gpc_pkg::J11]);
        table_next.out_group  = emit_idx_reg;
        table_next.cell_00    = bank_reg[emit_idx_reg][gpc_pkg::J00];
        table_next.cell_01    = bank_reg[emit_idx_reg][gpc_pkg::J01];
        table_next.cell_02    = c02;
        table_next.cell_10    = bank_reg[emit_idx_reg][gpc_pkg::J10];
        table_next.cell_11    = bank_reg[emit_idx_reg][gpc_pkg::J11];
        table_next.cell_12    = c12;
        table_next.cell_20    = gpc_pkg::sub_sat(bank_reg[emit_idx_reg][gpc_pkg::M2G0],
                                                 bank_reg[emit_idx_reg][gpc_pkg::J00],
                                                 bank_reg[emit_idx_reg][gpc_pkg::J10]);
        table_next.cell_21    = gpc_pkg::sub_sat(bank_reg[emit_idx_reg][gpc_pkg::M2G1],
                                                 bank_reg[emit_idx_reg][gpc_pkg::J01],
                                                 bank_reg[emit_idx_reg][gpc_pkg::J11]);
        table_next.cell_22    = gpc_pkg::sub_sat(bank_reg[emit_idx_reg][gpc_pkg::M2G2],
                                                 c02, c12);
        table_next.table_last = (emit_idx_reg == gpc_pkg::GRP_CASE_MALE);
    end

    // A table enters the output register whenever the register is free.
    assign emit_load = emit_busy_reg && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_busy_reg <= 1'b0;
            emit_idx_reg  <= gpc_pkg::GRP_CTRL_FEMALE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_take && pop_last_reg)
            begin
                emit_busy_reg <= 1'b1;
                emit_idx_reg  <= gpc_pkg::GRP_CTRL_FEMALE;
            end
            else if (emit_load)
            begin
                emit_idx_reg <= emit_idx_reg + gpc_pkg::GROUP_W'(1);
                if (emit_idx_reg == gpc_pkg::GRP_CASE_MALE)
                begin
                    emit_busy_reg <= 1'b0;
                end
            end
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_data_reg <= table_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A last word never overwrites the bank while tables are still leaving it.
    `GPC_ASSERT(a_last_waits_for_bank, (pop_valid_reg && pop_last_reg && emit_busy_reg) |=> (pop_valid_reg && pop_last_reg))

    // The flag marks the case-male table and no other.
    `GPC_ASSERT(a_last_flag_group, out_valid_reg |-> (out_data_reg.table_last == (out_data_reg.out_group == gpc_pkg::GRP_CASE_MALE)))

    // A ctrl-female table lands in the output register with more tables still to follow.
    `GPC_ASSERT(a_group_order, (emit_load && emit_idx_reg == gpc_pkg::GRP_CTRL_FEMALE) |=> (out_data_reg.out_group == gpc_pkg::GRP_CTRL_FEMALE && emit_busy_reg))

    // Nothing is offered while reset is held.
    `GPC_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |-> (!out_valid_reg && !emit_busy_reg))

endmodule

`default_nettype wire

>>> tb/tb_genotype_pair_contingency.sv
`default_nettype none

module tb_genotype_pair_contingency;

    // Counter ceiling: the word budget of a group, held to what a cell can carry.
    localparam int CAP_RAW   = gpc_pkg::MAX_WORDS_PER_GROUP_DEF * gpc_pkg::WORD_BITS_DEF;
    localparam int COUNT_CAP = (CAP_RAW > int'(gpc_pkg::CELL_MAX)) ? int'(gpc_pkg::CELL_MAX)
                                                                   : CAP_RAW;
    localparam logic [gpc_pkg::DATA_W-1:0] LANE_MASK =
        (gpc_pkg::WORD_BITS_DEF >= gpc_pkg::DATA_W) ? '1
            : ((64'd1 << gpc_pkg::WORD_BITS_DEF) - 64'd1);
    localparam logic [gpc_pkg::DATA_W-1:0] ALL_ONES = '1;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    gpc_pkg::in_word_t  in_data;
    logic               out_valid;
    logic               out_ready;
    gpc_pkg::out_word_t out_data;

    // Model state: nine counters per group and the tables still to arrive.
    int                 tally [gpc_pkg::NGROUPS][gpc_pkg::NSLOTS];
    gpc_pkg::out_word_t expected_tables [$];

    int errors;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;

    genotype_pair_contingency u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Marginal minus two joint counts, clamped at zero.
    function automatic int clamp_diff(input int m, input int a, input int b);
        int d;
        d = m - a - b;
        return (d < 0) ? 0 : d;
    endfunction

    // Adds one word to its group's counters; a closing word also produces the
    // four tables and clears every counter.
    function automatic void accumulate_word(input gpc_pkg::in_word_t w);
        logic [gpc_pkg::DATA_W-1:0] a0, a1, b0, b1, b2;
        int                         n [gpc_pkg::NSLOTS];
        int                         g;
        int                         c02, c12;
        gpc_pkg::out_word_t         t;
        a0 = w.snp1_g0_word & LANE_MASK;
        a1 = w.snp1_g1_word & LANE_MASK;
        b0 = w.snp2_g0_word & LANE_MASK;
        b1 = w.snp2_g1_word & LANE_MASK;
        b2 = w.snp2_g2_word & LANE_MASK;
        g  = int'(w.group);
        n[gpc_pkg::J00]  = $countones(a0 & b0);
        n[gpc_pkg::J01]  = $countones(a0 & b1);
        n[gpc_pkg::J10]  = $countones(a1 & b0);
        n[gpc_pkg::J11]  = $countones(a1 & b1);
        n[gpc_pkg::M1G0] = $countones(a0);
        n[gpc_pkg::M1G1] = $countones(a1);
        n[gpc_pkg::M2G0] = $countones(b0);
        n[gpc_pkg::M2G1] = $countones(b1);
        n[gpc_pkg::M2G2] = $countones(b2);
        for (int s = 0; s < gpc_pkg::NSLOTS; s++)
        begin
            tally[g][s] = (tally[g][s] + n[s] > COUNT_CAP) ? COUNT_CAP : tally[g][s] + n[s];
        end
        if (!w.end_of_pair)
        begin
            return;
        end
        for (int k = 0; k < gpc_pkg::NGROUPS; k++)
        begin
            c02 = clamp_diff(tally[k][gpc_pkg::M1G0], tally[k][gpc_pkg::J00],
                             tally[k][gpc_pkg::J01]);
            c12 = clamp_diff(tally[k][gpc_pkg::M1G1], tally[k][gpc_pkg::J10],
                             tally[k][gpc_pkg::J11]);
            t.out_group  = gpc_pkg::GROUP_W'(k);
            t.cell_00    = gpc_pkg::CNT_W'(tally[k][gpc_pkg::J00]);
            t.cell_01    = gpc_pkg::CNT_W'(tally[k][gpc_pkg::J01]);
            t.cell_02    = gpc_pkg::CNT_W'(c02);
            t.cell_10    = gpc_pkg::CNT_W'(tally[k][gpc_pkg::J10]);
            t.cell_11    = gpc_pkg::CNT_W'(tally[k][gpc_pkg::J11]);
            t.cell_12    = gpc_pkg::CNT_W'(c12);
            t.cell_20    = gpc_pkg::CNT_W'(clamp_diff(tally[k][gpc_pkg::M2G0],
                                                      tally[k][gpc_pkg::J00],
                                                      tally[k][gpc_pkg::J10]));
            t.cell_21    = gpc_pkg::CNT_W'(clamp_diff(tally[k][gpc_pkg::M2G1],
                                                      tally[k][gpc_pkg::J01],
                                                      tally[k][gpc_pkg::J11]));
            t.cell_22    = gpc_pkg::CNT_W'(clamp_diff(tally[k][gpc_pkg::M2G2], c02, c12));
            t.table_last = (k == gpc_pkg::NGROUPS - 1);
            expected_tables.push_back(t);
        end
        for (int k = 0; k < gpc_pkg::NGROUPS; k++)
        begin
            for (int s = 0; s < gpc_pkg::NSLOTS; s++)
            begin
                tally[k][s] = 0;
            end
        end
    endfunction

    function automatic logic [gpc_pkg::DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic gpc_pkg::in_word_t make_word(
        input logic [gpc_pkg::GROUP_W-1:0] grp,
        input logic [gpc_pkg::DATA_W-1:0]  a0,
        input logic [gpc_pkg::DATA_W-1:0]  a1,
        input logic [gpc_pkg::DATA_W-1:0]  b0,
        input logic [gpc_pkg::DATA_W-1:0]  b1,
        input logic [gpc_pkg::DATA_W-1:0]  b2,
        input logic                        is_last);
        gpc_pkg::in_word_t w;
        w.group        = grp;
        w.snp1_g0_word = a0;
        w.snp1_g1_word = a1;
        w.snp2_g0_word = b0;
        w.snp2_g1_word = b1;
        w.snp2_g2_word = b2;
        w.end_of_pair  = is_last;
        return w;
    endfunction

    // Genotype bitmaps that do not overlap, as real data would give them.
    function automatic gpc_pkg::in_word_t sample_word(
        input logic [gpc_pkg::GROUP_W-1:0] grp,
        input logic                        is_last);
        logic [gpc_pkg::DATA_W-1:0] a0, b0, b1;
        a0 = rand64();
        b0 = rand64();
        b1 = ~b0 & rand64();
        return make_word(grp, a0, ~a0 & rand64(), b0, b1, ~(b0 | b1) & rand64(), is_last);
    endfunction

    function automatic gpc_pkg::in_word_t noise_word(
        input logic [gpc_pkg::GROUP_W-1:0] grp,
        input logic                        is_last);
        return make_word(grp, rand64(), rand64(), rand64(), rand64(), rand64(), is_last);
    endfunction

    // Offers one word, idling each cycle before it with the set chance, and
    // waits for acceptance.
    task automatic send_word(input gpc_pkg::in_word_t w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        accumulate_word(w);
    endtask

    // Stops offering words and waits until every table has come out.
    task automatic wait_tables_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_tables.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
    endtask

    task automatic report_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        errors++;
    endtask

    // Receiver: random stalls, or a long hold-off when a test requests one.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Each accepted table is checked against the oldest expected one.
    always @(posedge clk)
    begin
        gpc_pkg::out_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tables.size() == 0)
            begin
                $display("%0t: unexpected table, expected none, got group %0d", $time,
                         out_data.out_group);
                errors++;
            end
            else
            begin
                e = expected_tables.pop_front();
                if (out_data.out_group !== e.out_group)
                    report_field("out_group", 32'(e.out_group), 32'(out_data.out_group));
                if (out_data.cell_00 !== e.cell_00)
                    report_field("cell_00", 32'(e.cell_00), 32'(out_data.cell_00));
                if (out_data.cell_01 !== e.cell_01)
                    report_field("cell_01", 32'(e.cell_01), 32'(out_data.cell_01));
                if (out_data.cell_02 !== e.cell_02)
                    report_field("cell_02", 32'(e.cell_02), 32'(out_data.cell_02));
                if (out_data.cell_10 !== e.cell_10)
                    report_field("cell_10", 32'(e.cell_10), 32'(out_data.cell_10));
                if (out_data.cell_11 !== e.cell_11)
                    report_field("cell_11", 32'(e.cell_11), 32'(out_data.cell_11));
                if (out_data.cell_12 !== e.cell_12)
                    report_field("cell_12", 32'(e.cell_12), 32'(out_data.cell_12));
                if (out_data.cell_20 !== e.cell_20)
                    report_field("cell_20", 32'(e.cell_20), 32'(out_data.cell_20));
                if (out_data.cell_21 !== e.cell_21)
                    report_field("cell_21", 32'(e.cell_21), 32'(out_data.cell_21));
                if (out_data.cell_22 !== e.cell_22)
                    report_field("cell_22", 32'(e.cell_22), 32'(out_data.cell_22));
                if (out_data.table_last !== e.table_last)
                    report_field("table_last", 32'(e.table_last), 32'(out_data.table_last));
            end
        end
    end

    // A pair of one empty word must give four all-zero tables.
    task automatic test_empty_pair();
        send_word(make_word(gpc_pkg::GRP_CTRL_FEMALE, '0, '0, '0, '0, '0, 1'b1));
        wait_tables_drained();
    endtask

    // Full, empty, single-bit and alternating words in every group.
    task automatic test_field_extremes();
        send_word(make_word(gpc_pkg::GRP_CTRL_FEMALE, ALL_ONES, '0, ALL_ONES, '0, '0, 1'b0));
        send_word(make_word(gpc_pkg::GRP_CTRL_MALE, '0, ALL_ONES, '0, ALL_ONES, '0, 1'b0));
        send_word(make_word(gpc_pkg::GRP_CASE_FEMALE, 64'h8000_0000_0000_0000, 64'h1,
                            64'h8000_0000_0000_0001, '0, 64'h1, 1'b0));
        send_word(make_word(gpc_pkg::GRP_CASE_MALE, 64'h5555_5555_5555_5555,
                            64'hAAAA_AAAA_AAAA_AAAA, 64'h3333_3333_3333_3333,
                            64'h4444_4444_4444_4444, 64'h8888_8888_8888_8888, 1'b0));
        send_word(make_word(gpc_pkg::GRP_CTRL_FEMALE, '0, '0, '0, '0, ALL_ONES, 1'b0));
        send_word(sample_word(gpc_pkg::GRP_CASE_MALE, 1'b1));
        send_word(make_word(gpc_pkg::GRP_CASE_MALE, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                            ALL_ONES, 1'b1));
        wait_tables_drained();
    endtask

    // Overlapping bitmaps drive derived cells below zero, which must clamp.
    task automatic test_inconsistent_bitmaps();
        send_word(make_word(gpc_pkg::GRP_CTRL_MALE, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                            ALL_ONES, 1'b0));
        send_word(make_word(gpc_pkg::GRP_CASE_FEMALE, ALL_ONES, ALL_ONES, '0, '0, '0, 1'b0));
        send_word(make_word(gpc_pkg::GRP_CTRL_FEMALE, '0, '0, ALL_ONES, ALL_ONES, '0, 1'b1));
        wait_tables_drained();
    endtask

    // The receiver holds off while short pairs keep coming, so the block backs up.
    task automatic test_output_stall();
        @(posedge clk);
        hold_cycles = 300;
        for (int i = 0; i < 24; i++)
        begin
            send_word(sample_word(gpc_pkg::GRP_CTRL_FEMALE
                                  + gpc_pkg::GROUP_W'($urandom_range(0, 3)), 1'b1));
        end
        wait_tables_drained();
    endtask

    // Many full words in one group build large counts before the pair closes.
    task automatic test_long_pair();
        for (int i = 0; i < 40; i++)
        begin
            send_word(make_word(gpc_pkg::GRP_CASE_MALE, ALL_ONES, ALL_ONES, ALL_ONES,
                                ALL_ONES, ALL_ONES, 1'b0));
        end
        send_word(sample_word(gpc_pkg::GRP_CTRL_MALE, 1'b1));
        wait_tables_drained();
    endtask

    // Random pairs, mostly well-formed bitmaps with some overlapping noise.
    task automatic test_random_pairs(input int n_words);
        int                          count;
        int                          pair_len;
        logic                        is_last;
        logic [gpc_pkg::GROUP_W-1:0] grp;
        count = 0;
        while (count < n_words)
        begin
            pair_len = $urandom_range(1, 10);
            for (int i = 0; i < pair_len && count < n_words; i++)
            begin
                grp     = gpc_pkg::GROUP_W'($urandom_range(0, 3));
                is_last = (i == pair_len - 1) || (count == n_words - 1);
                if ($urandom_range(99) < 85)
                    send_word(sample_word(grp, is_last));
                else
                    send_word(noise_word(grp, is_last));
                count++;
            end
        end
        wait_tables_drained();
    endtask

    initial
    begin
        errors        = 0;
        hold_cycles   = 0;
        send_idle_pct = 24;
        recv_idle_pct = 80;
        for (int k = 0; k < gpc_pkg::NGROUPS; k++)
        begin
            for (int s = 0; s < gpc_pkg::NSLOTS; s++)
            begin
                tally[k][s] = 0;
            end
        end
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_pair();
        test_field_extremes();
        test_inconsistent_bitmaps();
        test_random_pairs(45);

        send_idle_pct = 80;
        recv_idle_pct = 24;
        test_output_stall();
        test_random_pairs(45);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_long_pair();
        test_random_pairs(45);

        if (errors == 0)
            $display("tb_genotype_pair_contingency passed");
        else
            $display("tb_genotype_pair_contingency failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("tb_genotype_pair_contingency failed");
        $finish;
    end

endmodule

`default_nettype wire
